/* sv/mbet_pkg.sv */
// Shared constants, register codes and types of the Mandelbrot escape-time block.
package mbet_pkg;

    // Default values of the top-level parameters.
    localparam int DEF_COORD_FRAC_BITS = 28;
    localparam int DEF_COUNT_BITS      = 16;
    localparam int DEF_PIXEL_BITS      = 12;

    // Fixed register and port widths.
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int COORD_W    = 32;
    localparam int STEP_W     = 31;
    localparam int ITER_W     = 16;

    // Depth of the point queue between the mapper and the iteration core.
    localparam int QUEUE_DEPTH = 4;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_RE   = 3'd0,
        CFG_MAX_IM   = 3'd1,
        CFG_X_STEP   = 3'd2,
        CFG_Y_STEP   = 3'd3,
        CFG_MAX_ITER = 3'd4
    } t_cfg_idx;

    // Reset values of the registers.
    localparam logic signed [COORD_W-1:0] RST_MIN_RE   = -32'sd671088640;
    localparam logic signed [COORD_W-1:0] RST_MAX_IM   = 32'sd302055424;
    localparam logic [STEP_W-1:0]         RST_X_STEP   = 31'd629474;
    localparam logic [STEP_W-1:0]         RST_Y_STEP   = 31'd629474;
    localparam logic [ITER_W-1:0]         RST_MAX_ITER = 16'd2500;

    // Window settings used by the coordinate mapper.
    typedef struct packed {
        logic signed [COORD_W-1:0] min_re;
        logic signed [COORD_W-1:0] max_im;
        logic [STEP_W-1:0]         x_step;
        logic [STEP_W-1:0]         y_step;
    } t_map_cfg;

endpackage

/* sv/mbet_front.sv */
// Front end: accepts pixel beats and maps them to points of the complex plane.
module mbet_front #(
    parameter int PIXEL_BITS = mbet_pkg::DEF_PIXEL_BITS,
    parameter int C_W        = PIXEL_BITS + mbet_pkg::STEP_W + 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  mbet_pkg::t_map_cfg     i_cfg,
    input  logic                   i_pix_valid,
    output logic                   o_pix_ready,
    input  logic [PIXEL_BITS-1:0]  i_col,
    input  logic [PIXEL_BITS-1:0]  i_row,
    output logic                   o_pt_valid,
    input  logic                   i_pt_ready,
    output logic signed [C_W-1:0]  o_c_re,
    output logic signed [C_W-1:0]  o_c_im
);
    import mbet_pkg::*;

    localparam int PROD_W = PIXEL_BITS + STEP_W;

    logic              r_pv;
    logic [PROD_W-1:0] r_re_off;
    logic [PROD_W-1:0] r_im_off;
    logic              pix_acc;

    // The offset stage frees up whenever its point moves into the queue.
    assign o_pix_ready = !r_pv || i_pt_ready;
    assign pix_acc     = i_pix_valid && o_pix_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (o_pix_ready) begin
            r_pv <= i_pix_valid;
        end
    end

    // Scale the pixel indexes by the step sizes; the products are exact.
    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_re_off <= PROD_W'(i_col) * PROD_W'(i_cfg.x_step);
            r_im_off <= PROD_W'(i_row) * PROD_W'(i_cfg.y_step);
        end
    end

    // Add the window origin; the sums fit without overflow.
    assign o_pt_valid = r_pv;
    assign o_c_re     = C_W'(i_cfg.min_re) + C_W'(r_re_off);
    assign o_c_im     = C_W'(i_cfg.max_im) - C_W'(r_im_off);

endmodule

/* sv/mbet_queue.sv */
// Short queue of mapped points between the front end and the iteration core.
module mbet_queue #(
    parameter int DATA_W = 2 * (mbet_pkg::DEF_PIXEL_BITS + mbet_pkg::STEP_W + 2)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DATA_W-1:0] o_data
);
    import mbet_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wp;
    logic [PTR_W-1:0]  r_rp;
    logic [CNT_W-1:0]  r_cnt;
    logic              push;
    logic              pop;

    assign o_ready = (r_cnt != CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rp];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Pointers and fill count; the depth is a power of two so pointers wrap.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + PTR_W'(1);
            end
            if (pop) begin
                r_rp <= r_rp + PTR_W'(1);
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* sv/mbet_core.sv */
// Back end: iterates z = z*z + c for one point and holds the result beat.
module mbet_core #(
    parameter int COORD_FRAC_BITS = mbet_pkg::DEF_COORD_FRAC_BITS,
    parameter int C_W             = mbet_pkg::DEF_PIXEL_BITS + mbet_pkg::STEP_W + 2
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [mbet_pkg::ITER_W-1:0] i_max_iter,
    input  logic                        i_pt_valid,
    output logic                        o_pt_ready,
    input  logic signed [C_W-1:0]       i_c_re,
    input  logic signed [C_W-1:0]       i_c_im,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output logic [mbet_pkg::ITER_W-1:0] o_count,
    output logic                        o_in_set
);
    import mbet_pkg::*;

    localparam int F    = COORD_FRAC_BITS;
    localparam int MW   = F + 2;                          // magnitude of a stored iterate
    localparam int XW   = F + 3;                          // signed stored iterate
    localparam int SQ_W = F + 3;                          // truncated square
    localparam int PM_W = F + 4;                          // truncated cross term
    localparam int PW   = 2 * MW;                         // raw product
    localparam int NW   = ((C_W > F + 5) ? C_W : F + 5) + 1;  // new iterate sums

    localparam logic signed [NW-1:0] POS_TWO  = signed'(NW'(1) << (F + 1));
    localparam logic signed [NW-1:0] NEG_TWO  = -POS_TWO;
    localparam logic [SQ_W:0]        SUM_FOUR = (SQ_W + 1)'(1) << (F + 2);
    localparam logic signed [XW-1:0] Z_TWO    = signed'(XW'(1) << (F + 1));
    localparam logic [SQ_W-1:0]      SQ_FOUR  = SQ_W'(1) << (F + 2);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_ADD  = 3'b010,
        ST_MUL  = 3'b100
    } t_state;

    t_state                 r_state;
    t_state                 n_state;
    logic signed [C_W-1:0]  r_cre;
    logic signed [C_W-1:0]  r_cim;
    logic signed [XW-1:0]   r_x;
    logic signed [XW-1:0]   r_y;
    logic [SQ_W-1:0]        r_x2;
    logic [SQ_W-1:0]        r_y2;
    logic [PM_W-1:0]        r_pm;
    logic                   r_pneg;
    logic [ITER_W-1:0]      r_n;
    logic                   r_ov;
    logic [ITER_W-1:0]      r_count;
    logic                   r_in_set;

    logic [SQ_W:0]          sq_sum;
    logic                   run;
    logic [ITER_W-1:0]      n_inc;
    logic signed [NW-1:0]   nx;
    logic signed [NW-1:0]   ny;
    logic [NW-1:0]          pm_ext;
    logic                   escape;
    logic                   finish;
    logic                   out_free;
    logic [ITER_W-1:0]      fin_n;
    logic [MW-1:0]          mag_x;
    logic [MW-1:0]          mag_y;
    logic [PW-1:0]          sq_x;
    logic [PW-1:0]          sq_y;
    logic [PW-1:0]          p_xy;

    // Loop test at the top of an iteration: bounded squares and count below limit.
    assign sq_sum = (SQ_W + 1)'(r_x2) + (SQ_W + 1)'(r_y2);
    assign run    = (sq_sum <= SUM_FOUR) && (r_n < i_max_iter);
    assign n_inc  = r_n + ITER_W'(1);

    // Add step: new iterate from the registered squares and cross term.
    assign pm_ext = NW'(r_pm);
    assign nx     = NW'(r_x2) - NW'(r_y2) + NW'(r_cre);
    assign ny     = NW'(r_cim) + (r_pneg ? -pm_ext : pm_ext);
    assign escape = (nx > POS_TWO) || (nx < NEG_TWO) || (ny > POS_TWO) || (ny < NEG_TWO);

    // A point is done when the loop test fails or a part of the new iterate exceeds 2 in magnitude.
    assign out_free = !r_ov || i_res_ready;
    assign finish   = (r_state == ST_ADD) && (!run || escape);
    assign fin_n    = run ? n_inc : r_n;

    // Multiply step: squares and cross term on magnitudes, truncated toward zero.
    assign mag_x = MW'(r_x[XW-1] ? -r_x : r_x);
    assign mag_y = MW'(r_y[XW-1] ? -r_y : r_y);
    assign sq_x  = PW'(mag_x) * PW'(mag_x);
    assign sq_y  = PW'(mag_y) * PW'(mag_y);
    assign p_xy  = PW'(mag_x) * PW'(mag_y);

    assign o_pt_ready = (r_state == ST_IDLE);

    // Sequencer: load, then alternate add and multiply steps until done.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_pt_valid) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                if (finish) begin
                    if (out_free) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_ADD;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Iteration datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_pt_valid) begin
                    r_cre  <= i_c_re;
                    r_cim  <= i_c_im;
                    r_x    <= '0;
                    r_y    <= '0;
                    r_x2   <= '0;
                    r_y2   <= '0;
                    r_pm   <= '0;
                    r_pneg <= 1'b0;
                    r_n    <= '0;
                end
            end
            ST_ADD: begin
                if (!finish) begin
                    r_x <= XW'(nx);
                    r_y <= XW'(ny);
                    r_n <= n_inc;
                end
            end
            ST_MUL: begin
                r_x2   <= sq_x[F+SQ_W-1:F];
                r_y2   <= sq_y[F+SQ_W-1:F];
                r_pm   <= p_xy[F+PM_W-2:F-1];
                r_pneg <= r_x[XW-1] ^ r_y[XW-1];
            end
            default: begin
                r_n <= r_n;
            end
        endcase
    end

    // Result register; it frees the core to take the next point while a beat waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (finish && out_free) begin
            r_ov <= 1'b1;
        end else if (i_res_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish && out_free) begin
            r_count  <= fin_n;
            r_in_set <= (fin_n == i_max_iter);
        end
    end

    assign o_res_valid = r_ov;
    assign o_count     = r_count;
    assign o_in_set    = r_in_set;

`ifndef NO_ASSERTIONS
    // An iterate kept for the multiply step lies inside the escape radius.
    a_iterate_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |->
            (r_x <= Z_TWO && r_x >= -Z_TWO && r_y <= Z_TWO && r_y >= -Z_TWO))
        else $error("stored iterate outside the escape radius");

    // Every add step that continues the loop counts exactly one iteration.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |-> (r_n == $past(r_n) + ITER_W'(1)))
        else $error("iteration count did not advance by one");

    // Squares formed from a bounded iterate never exceed four.
    a_square_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADD && $past(r_state) == ST_MUL) |->
            (r_x2 <= SQ_FOUR && r_y2 <= SQ_FOUR))
        else $error("truncated square exceeds four");

    // A finished point waits in the add step while the result register is full.
    a_hold_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (finish && !out_free) |=> (r_state == ST_ADD && r_ov))
        else $error("finished point lost while the result beat was pending");
`endif

endmodule

/* sv/mandelbrot_escape_time.sv */
// Top level of the Mandelbrot escape-time evaluator: registers, mapper, queue and core.
//
// Each pixel beat (column, row) is mapped to c = min_re + column*x_step +
// i*(max_im - row*y_step) in signed Q17.28 and iterated as z = z*z + c from zero until
// |z|^2 exceeds 4 or the count reaches max_iterations; the result beat carries the count
// and an in-set flag. The front end registers the mapped offsets, and a mapped point
// reaches the core through a four-entry queue, so mapping overlaps the iteration of the
// previous point. The iteration core uses one multiply step and one add step per
// iteration, with a default limit of 2500 iterations, and it loads the next point while
// the previous result beat is still waiting. The user must write the configuration
// registers only while no point is in flight; the block itself does not enforce this.
module mandelbrot_escape_time #(
    parameter int COORD_FRAC_BITS = mbet_pkg::DEF_COORD_FRAC_BITS,
    parameter int COUNT_BITS      = mbet_pkg::DEF_COUNT_BITS,
    parameter int PIXEL_BITS      = mbet_pkg::DEF_PIXEL_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mbet_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mbet_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_pixel_valid,
    output logic                            o_pixel_ready,
    input  logic [PIXEL_BITS-1:0]           i_pixel_col,
    input  logic [PIXEL_BITS-1:0]           i_pixel_row,
    output logic                            o_result_valid,
    input  logic                            i_result_ready,
    output logic [COUNT_BITS-1:0]           o_iteration_count,
    output logic                            o_in_set
);
    import mbet_pkg::*;

    localparam int C_W = PIXEL_BITS + STEP_W + 2;

    t_map_cfg              r_cfg;
    logic [ITER_W-1:0]     r_max_iter;
    logic                  pt_valid;
    logic                  pt_ready;
    logic signed [C_W-1:0] pt_c_re;
    logic signed [C_W-1:0] pt_c_im;
    logic                  q_valid;
    logic                  q_ready;
    logic [2*C_W-1:0]      q_data;
    logic [ITER_W-1:0]     core_count;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_re <= RST_MIN_RE;
            r_cfg.max_im <= RST_MAX_IM;
            r_cfg.x_step <= RST_X_STEP;
            r_cfg.y_step <= RST_Y_STEP;
            r_max_iter   <= RST_MAX_ITER;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MIN_RE:   r_cfg.min_re <= COORD_W'(i_cfg_data);
                CFG_MAX_IM:   r_cfg.max_im <= COORD_W'(i_cfg_data);
                CFG_X_STEP:   r_cfg.x_step <= i_cfg_data[STEP_W-1:0];
                CFG_Y_STEP:   r_cfg.y_step <= i_cfg_data[STEP_W-1:0];
                CFG_MAX_ITER: r_max_iter   <= i_cfg_data[ITER_W-1:0];
                default: begin
                    r_max_iter <= r_max_iter;
                end
            endcase
        end
    end

    // Coordinate mapper.
    mbet_front #(
        .PIXEL_BITS (PIXEL_BITS),
        .C_W        (C_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_pix_valid (i_pixel_valid),
        .o_pix_ready (o_pixel_ready),
        .i_col       (i_pixel_col),
        .i_row       (i_pixel_row),
        .o_pt_valid  (pt_valid),
        .i_pt_ready  (pt_ready),
        .o_c_re      (pt_c_re),
        .o_c_im      (pt_c_im)
    );

    // Point queue.
    mbet_queue #(
        .DATA_W (2 * C_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pt_valid),
        .o_ready (pt_ready),
        .i_data  ({pt_c_re, pt_c_im}),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_data)
    );

    // Iteration core.
    mbet_core #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .C_W             (C_W)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_max_iter  (r_max_iter),
        .i_pt_valid  (q_valid),
        .o_pt_ready  (q_ready),
        .i_c_re      (signed'(q_data[2*C_W-1:C_W])),
        .i_c_im      (signed'(q_data[C_W-1:0])),
        .o_res_valid (o_result_valid),
        .i_res_ready (i_result_ready),
        .o_count     (core_count),
        .o_in_set    (o_in_set)
    );

    assign o_iteration_count = COUNT_BITS'(core_count);

endmodule
